// ===== rtl/atcd_pkg.sv =====
// Shared types and constants for the alarm tone cadence detector.
// No dependencies; imported by every module of the block.
`default_nettype none
package atcd_pkg;

   localparam int unsigned DivWidth  = 40;
   localparam int unsigned DivCntW   = 6;

   localparam logic [31:0] FloorResetQ16 = 32'd1966080;
   localparam logic [31:0] FloorMinQ16   = 32'd786432;
   localparam logic [10:0] AlphaDownQ16  = 11'd1311;
   localparam logic [7:0]  AlphaUpQ16    = 8'd197;
   localparam logic [2:0]  ToneIntegMax  = 3'd5;
   localparam logic [2:0]  ToneOnLevel   = 3'd3;
   localparam logic [31:0] BurstMinMs    = 32'd280;
   localparam logic [31:0] BurstMaxMs    = 32'd850;
   localparam logic [31:0] GapMinMs      = 32'd220;
   localparam logic [31:0] GapMaxMs      = 32'd850;
   localparam logic [31:0] ConfirmMs     = 32'd900;
   localparam logic [31:0] DriftMaxQ8    = 32'd153600;
   localparam logic [14:0] SmokeLowHz    = 15'd2800;
   localparam logic [14:0] SmokeHighHz   = 15'd3300;
   localparam logic [2:0]  DropoutLimit  = 3'd5;
   localparam logic [2:0]  CoBursts      = 3'd3;
   localparam logic [2:0]  BurstsRestart = 3'd4;
   localparam logic [15:0] PatDivisor    = 16'd100;
   // blend divide by 100: drop two bits, then multiply by ceil(2^34 / 25)
   localparam logic [29:0] PatRecip      = 30'd687194768;

   localparam logic [2:0] RegMinRms      = 3'd0;
   localparam logic [2:0] RegMinRatio    = 3'd1;
   localparam logic [2:0] RegSmokeRms    = 3'd2;
   localparam logic [2:0] RegSmokeRatio  = 3'd3;
   localparam logic [2:0] RegSmokeFrames = 3'd4;
   localparam logic [2:0] RegCooldown    = 3'd5;
   localparam logic [2:0] RegCoLow       = 3'd6;
   localparam logic [2:0] RegCoHigh      = 3'd7;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EVAL   = 7'b0000010,
      ST_ENDCHK = 7'b0000100,
      ST_DIVF   = 7'b0001000,
      ST_FAPPLY = 7'b0010000,
      ST_BLEND  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic blend_load;
      logic fapply;
      logic papply;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic end_pend;
      logic div_idle;
      logic blend_go;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/alarm_tone_cadence_detector.sv =====
// Top level of the alarm tone cadence detector.
// Depends on atcd_pkg, atcd_ctrl, atcd_dp (which holds atcd_div).
//
// Usage:
//   req_* carries one word of frame features (RMS, tonal ratio, peak Hz,
//   ms timestamp) under valid/ready; rsp_* returns one word per frame
//   (smoke and CO flags, tone latch, noise floor, burst count).
//   csr_we/csr_index/csr_wdata write one threshold register per cycle;
//   write only while the block is idle.
// Frame flow:
//   Most frames run evaluate, end check and finish before rsp_valid
//   rises. A frame that closes a valid burst runs the restoring divider
//   for the burst average, then a drift check and, when a pattern exists
//   and the average stays within the drift bound, the blend divide by 100
//   (reciprocal multiply). One frame is in work at a time; req_ready is
//   high only between frames.
// Reset:
//   Synchronous, active high; loads register defaults and the detector
//   state (floor 30.0), drops rsp_valid.
// Stall:
//   A finished word sits in the output register; the next frame is taken
//   and worked on, and holds in its finish step until the receiver drains.
`default_nettype none
module alarm_tone_cadence_detector
   import atcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [19:0] req_frame_rms,
   input  wire logic [15:0] req_tonal_ratio,
   input  wire logic [14:0] req_peak_hz,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_smoke_alarm,
   output logic             rsp_co_alarm,
   output logic             rsp_tone_active,
   output logic [19:0]      rsp_floor_level,
   output logic [2:0]       rsp_burst_count,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   cmd_type    cmd;
   status_type st;

   // sequencer: one frame through its steps
   atcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // state, arithmetic and the output register
   atcd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_frame_rms   (req_frame_rms),
      .req_tonal_ratio (req_tonal_ratio),
      .req_peak_hz     (req_peak_hz),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_smoke_alarm (rsp_smoke_alarm),
      .rsp_co_alarm    (rsp_co_alarm),
      .rsp_tone_active (rsp_tone_active),
      .rsp_floor_level (rsp_floor_level),
      .rsp_burst_count (rsp_burst_count)
   );
endmodule
`default_nettype wire

// ===== rtl/atcd_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on atcd_pkg for widths.
`default_nettype none
module atcd_div
   import atcd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DivWidth-1:0] dividend,
   input  wire logic [15:0]         divisor,
   output logic                     idle,
   output logic [DivWidth-1:0]      quotient
);
   logic [DivWidth-1:0] q_ff, q_in;
   logic [15:0]         r_ff, r_in;
   logic [15:0]         d_ff, d_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [16:0]         trial;
   logic [17:0]         diff;

   always_comb begin
      trial  = {r_ff, q_ff[DivWidth-1]};
      diff   = {1'b0, trial} - {2'b00, d_ff};
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = DivCntW'(DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the remainder when the trial subtract goes negative
         if (!diff[17]) begin
            r_in = diff[15:0];
            q_in = {q_ff[DivWidth-2:0], 1'b1};
         end else begin
            r_in = trial[15:0];
            q_in = {q_ff[DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign idle     = !busy_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

// ===== rtl/atcd_dp.sv =====
// Datapath: configuration, detector state, frame evaluation, output word.
// Depends on atcd_pkg and atcd_div.
`default_nettype none
module atcd_dp
   import atcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       st,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_wdata,
   input  wire logic [19:0] req_frame_rms,
   input  wire logic [15:0] req_tonal_ratio,
   input  wire logic [14:0] req_peak_hz,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_smoke_alarm,
   output logic             rsp_co_alarm,
   output logic             rsp_tone_active,
   output logic [19:0]      rsp_floor_level,
   output logic [2:0]       rsp_burst_count
);
   // configuration
   logic [19:0] min_rms_ff, smoke_rms_ff;
   logic [15:0] min_ratio_ff, smoke_ratio_ff, smoke_frames_ff, cooldown_ms_ff;
   logic [14:0] co_low_ff, co_high_ff;

   // captured frame
   logic [19:0] rms_ff;
   logic [15:0] ratio_ff;
   logic [14:0] hz_ff;
   logic [31:0] now_ff;

   // detector state
   logic [31:0] floor_ff, floor_in;
   logic [2:0]  integ_ff, integ_in;
   logic        latch_ff, latch_in;
   logic [31:0] cool_ff, cool_in;
   logic [15:0] sig_frames_ff, sig_frames_in;
   logic [2:0]  sig_drop_ff, sig_drop_in;
   logic [31:0] bstart_ff, bstart_in;
   logic [31:0] bend_ff, bend_in;
   logic [2:0]  bursts_ff, bursts_in;
   logic [23:0] pat_ff, pat_in;
   logic [31:0] hsum_ff, hsum_in;
   logic [15:0] hcnt_ff, hcnt_in;
   logic        svalid_ff, svalid_in;
   logic        end_pend_ff, end_pend_in;
   logic        smoke_ff, smoke_in;

   // output word
   logic        rv_ff, rv_in;
   logic        o_smoke_ff, o_co_ff, o_tone_ff;
   logic [19:0] o_floor_ff;
   logic [2:0]  o_bursts_ff;

   // divider
   logic                div_idle;
   logic [DivWidth-1:0] div_q;
   logic [DivWidth-1:0] div_dividend;
   logic [15:0]         div_divisor;

   // pattern blend, numerator over four held for the reciprocal multiply
   logic [28:0] blend_ff;
   logic [58:0] blend_prod;

   // evaluation terms
   logic [31:0] rms_q16;
   logic [34:0] thr_floor, thr_min, thr2;
   logic        level_ok, tone, smoke_sig, cooldown, co_hit;
   logic [31:0] floor_dist, step_down, step_up;
   logic [42:0] prod_down;
   logic [39:0] prod_up;
   logic [31:0] floor_mv;
   logic [31:0] gap, dur, since_end;
   logic [31:0] freq, drift;
   logic [39:0] blend_num;

   assign rms_q16   = {rms_ff, 12'd0};
   assign thr_floor = {3'd0, floor_ff} + {1'b0, floor_ff, 2'b00};
   assign thr_min   = {2'b00, min_rms_ff, 13'd0};
   assign thr2      = (thr_floor > thr_min) ? thr_floor : thr_min;
   assign level_ok  = {2'b00, rms_ff, 13'd0} >= thr2;
   assign tone      = level_ok && (ratio_ff >= min_ratio_ff);
   assign smoke_sig = (rms_ff >= smoke_rms_ff) && (ratio_ff >= smoke_ratio_ff)
                      && (hz_ff >= SmokeLowHz) && (hz_ff <= SmokeHighHz);
   assign cooldown  = (now_ff - cool_ff) >> 31 != 32'd0;

   assign floor_dist = (rms_q16 < floor_ff) ? floor_ff - rms_q16 : rms_q16 - floor_ff;
   assign prod_down = {11'd0, floor_dist} * {32'd0, AlphaDownQ16} + 43'd32768;
   assign prod_up   = {8'd0, floor_dist} * {32'd0, AlphaUpQ16} + 40'd32768;
   assign step_down = prod_down[42:16] == 27'd0 ? 32'd0 : 32'(prod_down[42:16]);
   assign step_up   = 32'(prod_up[39:16]);
   assign floor_mv  = (rms_q16 < floor_ff) ? floor_ff - step_down : floor_ff + step_up;

   assign gap       = now_ff - bend_ff;
   assign dur       = now_ff - bstart_ff;
   assign since_end = now_ff - bend_ff;

   assign freq      = (hcnt_ff == 16'd0) ? 32'd0 : div_q[31:0];
   assign drift     = (freq > {8'd0, pat_ff}) ? freq - {8'd0, pat_ff}
                                              : {8'd0, pat_ff} - freq;
   assign blend_num = ({16'd0, pat_ff} << 6) + {16'd0, pat_ff}
                    + ({8'd0, freq} << 5) + ({8'd0, freq} << 1) + {8'd0, freq}
                    + 40'd50;
   // numerator stays below 2^31, so its top bits past 30 are always zero
   assign blend_prod = {30'd0, blend_ff} * {29'd0, PatRecip};

   assign co_hit = !latch_ff && (bursts_ff == CoBursts)
                   && (pat_ff >= {1'b0, co_low_ff, 8'd0})
                   && (pat_ff <= {1'b0, co_high_ff, 8'd0})
                   && (since_end >= ConfirmMs);

   assign div_dividend = {hsum_ff, 8'd0};
   assign div_divisor  = hcnt_ff;

   atcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .idle     (div_idle),
      .quotient (div_q)
   );

   always_comb begin
      floor_in      = floor_ff;
      integ_in      = integ_ff;
      latch_in      = latch_ff;
      cool_in       = cool_ff;
      sig_frames_in = sig_frames_ff;
      sig_drop_in   = sig_drop_ff;
      bstart_in     = bstart_ff;
      bend_in       = bend_ff;
      bursts_in     = bursts_ff;
      pat_in        = pat_ff;
      hsum_in       = hsum_ff;
      hcnt_in       = hcnt_ff;
      svalid_in     = svalid_ff;
      end_pend_in   = end_pend_ff;
      smoke_in      = smoke_ff;
      rv_in         = rv_ff && !rsp_ready;

      if (cmd.eval) begin
         end_pend_in = 1'b0;
         smoke_in    = 1'b0;
         // smoke signature with dropout tolerance
         if (smoke_sig) begin
            sig_drop_in = '0;
            if (sig_frames_ff != 16'hFFFF) sig_frames_in = sig_frames_ff + 1'b1;
            smoke_in = (sig_frames_in == smoke_frames_ff);
         end else begin
            sig_drop_in = sig_drop_ff + 1'b1;
            if (sig_drop_in >= DropoutLimit) begin
               sig_frames_in = '0;
               sig_drop_in   = '0;
            end
         end
         // learn the floor on quiet frames
         if (!level_ok) begin
            floor_in = (floor_mv < FloorMinQ16) ? FloorMinQ16 : floor_mv;
         end
         if (tone) begin
            if (integ_ff < ToneIntegMax) integ_in = integ_ff + 1'b1;
         end else if (integ_ff != 3'd0) begin
            integ_in = integ_ff - 1'b1;
         end
         if (tone && hcnt_ff != 16'hFFFF) begin
            hsum_in = hsum_ff + {17'd0, hz_ff};
            hcnt_in = hcnt_ff + 1'b1;
         end
         if (!latch_ff && integ_in >= ToneOnLevel) begin
            // tone start
            latch_in = 1'b1;
            hsum_in  = {17'd0, hz_ff};
            hcnt_in  = 16'd1;
            if (!cooldown) begin
               if (bursts_ff != 3'd0 &&
                   (gap < GapMinMs || gap > GapMaxMs || bursts_ff >= BurstsRestart)) begin
                  bend_in   = '0;
                  bursts_in = '0;
                  pat_in    = '0;
                  hsum_in   = '0;
                  hcnt_in   = '0;
               end
               bstart_in = now_ff;
               svalid_in = 1'b1;
            end
         end else if (latch_ff && integ_in == 3'd0) begin
            // tone end: qualify duration, frequency check follows
            latch_in = 1'b0;
            if (!cooldown && svalid_ff) begin
               if (dur < BurstMinMs || dur > BurstMaxMs) begin
                  bstart_in = '0;
                  bend_in   = '0;
                  bursts_in = '0;
                  pat_in    = '0;
                  hsum_in   = '0;
                  hcnt_in   = '0;
                  svalid_in = 1'b0;
               end else begin
                  end_pend_in = 1'b1;
               end
            end
         end
      end

      if (cmd.fapply) begin
         if (bursts_ff == 3'd0) begin
            pat_in    = freq[23:0];
            bursts_in = 3'd1;
            bend_in   = now_ff;
         end else if (drift > DriftMaxQ8) begin
            bstart_in = '0;
            bend_in   = '0;
            bursts_in = '0;
            pat_in    = '0;
            hsum_in   = '0;
            hcnt_in   = '0;
            svalid_in = 1'b0;
         end
      end

      if (cmd.papply) begin
         pat_in  = blend_prod[57:34];
         if (bursts_ff != 3'd7) bursts_in = bursts_ff + 1'b1;
         bend_in = now_ff;
      end

      if (cmd.finish) begin
         rv_in = 1'b1;
         if (co_hit) begin
            cool_in = now_ff + {16'd0, cooldown_ms_ff};
         end
         if (co_hit || (!latch_ff && bursts_ff != 3'd0 && bursts_ff < 3'd3
                        && since_end > GapMaxMs)) begin
            bstart_in = '0;
            bend_in   = '0;
            bursts_in = '0;
            pat_in    = '0;
            hsum_in   = '0;
            hcnt_in   = '0;
            svalid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rms_ff      <= 20'd480;
         min_ratio_ff    <= 16'd1311;
         smoke_rms_ff    <= 20'd3200;
         smoke_ratio_ff  <= 16'd655;
         smoke_frames_ff <= 16'd150;
         cooldown_ms_ff  <= 16'd3000;
         co_low_ff       <= 15'd2850;
         co_high_ff      <= 15'd3450;
         floor_ff        <= FloorResetQ16;
         integ_ff        <= '0;
         latch_ff        <= 1'b0;
         cool_ff         <= '0;
         sig_frames_ff   <= '0;
         sig_drop_ff     <= '0;
         bstart_ff       <= '0;
         bend_ff         <= '0;
         bursts_ff       <= '0;
         pat_ff          <= '0;
         hsum_ff         <= '0;
         hcnt_ff         <= '0;
         svalid_ff       <= 1'b0;
         end_pend_ff     <= 1'b0;
         smoke_ff        <= 1'b0;
         rv_ff           <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               RegMinRms:      min_rms_ff      <= csr_wdata;
               RegMinRatio:    min_ratio_ff    <= csr_wdata[15:0];
               RegSmokeRms:    smoke_rms_ff    <= csr_wdata;
               RegSmokeRatio:  smoke_ratio_ff  <= csr_wdata[15:0];
               RegSmokeFrames: smoke_frames_ff <= csr_wdata[15:0];
               RegCooldown:    cooldown_ms_ff  <= csr_wdata[15:0];
               RegCoLow:       co_low_ff       <= csr_wdata[14:0];
               RegCoHigh:      co_high_ff      <= csr_wdata[14:0];
               default:        ;
            endcase
         end
         floor_ff      <= floor_in;
         integ_ff      <= integ_in;
         latch_ff      <= latch_in;
         cool_ff       <= cool_in;
         sig_frames_ff <= sig_frames_in;
         sig_drop_ff   <= sig_drop_in;
         bstart_ff     <= bstart_in;
         bend_ff       <= bend_in;
         bursts_ff     <= bursts_in;
         pat_ff        <= pat_in;
         hsum_ff       <= hsum_in;
         hcnt_ff       <= hcnt_in;
         svalid_ff     <= svalid_in;
         end_pend_ff   <= end_pend_in;
         smoke_ff      <= smoke_in;
         rv_ff         <= rv_in;
      end
      if (cmd.load) begin
         rms_ff   <= req_frame_rms;
         ratio_ff <= req_tonal_ratio;
         hz_ff    <= req_peak_hz;
         now_ff   <= req_now_ms;
      end
      if (cmd.blend_load) begin
         blend_ff <= blend_num[30:2];
      end
      if (cmd.finish) begin
         o_smoke_ff  <= smoke_ff;
         o_co_ff     <= co_hit;
         o_tone_ff   <= latch_ff;
         o_floor_ff  <= floor_ff[31:12];
         o_bursts_ff <= co_hit ? 3'd0 : bursts_in;
      end
   end

   assign st.end_pend = end_pend_ff;
   assign st.div_idle = div_idle;
   assign st.blend_go = (bursts_ff != 3'd0) && (drift <= DriftMaxQ8);
   assign st.out_free = !rv_ff || rsp_ready;

   assign rsp_valid       = rv_ff;
   assign rsp_smoke_alarm = o_smoke_ff;
   assign rsp_co_alarm    = o_co_ff;
   assign rsp_tone_active = o_tone_ff;
   assign rsp_floor_level = o_floor_ff;
   assign rsp_burst_count = o_bursts_ff;
endmodule
`default_nettype wire

// ===== rtl/atcd_ctrl.sv =====
// Sequencer for one frame: evaluate, divide, blend, deliver.
// Depends on atcd_pkg.
`default_nettype none
module atcd_ctrl
   import atcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type st,
   output cmd_type         cmd
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_ENDCHK;
         end
         ST_ENDCHK: begin
            if (st.end_pend) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVF;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVF: begin
            if (st.div_idle) state_in = ST_FAPPLY;
         end
         ST_FAPPLY: begin
            cmd.fapply = 1'b1;
            if (st.blend_go) begin
               cmd.blend_load = 1'b1;
               state_in       = ST_BLEND;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_BLEND: begin
            cmd.papply = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
endmodule
`default_nettype wire
